[rtl/gbc_pkg.sv]
// Package for the clipped 1-bit glyph blitter: payload structs, controller
// states, command/status bundles and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

	localparam int WORD_BITS     = 32;
	localparam int MAX_ROW_WORDS = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_ROW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INK_BLACK     = 3'd5;

	// Input item operation codes
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic [7:0]         glyph_width;
		logic [7:0]         glyph_height;
		logic [31:0]        bitmap_word;
	} glyph_item_t;

	typedef struct packed {
		logic [19:0] word_address;
		logic [31:0] pixel_mask;
		logic        clear_pixels;
		logic        last;
	} blit_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEG,
		ST_EMIT,
		ST_FLUSH
	} gbc_state_t;

	typedef struct packed {
		logic load_hdr;
		logic load_data;
		logic seg_calc;
		logic emit;
		logic next_word;
		logic advance;
		logic flush;
	} gbc_cmd_t;

	typedef struct packed {
		logic active;
		logic vis;
		logic word_end;
		logic item_end;
		logic can_emit;
		logic out_free;
	} gbc_status_t;

endpackage

`default_nettype wire

[rtl/gbc_ctrl.sv]
// Controller of the glyph blitter: walks each data word segment by segment
// and word by word. Depends on gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  glyph_valid,
	input  wire                  glyph_op,
	output logic                 glyph_ready,
	input  gbc_pkg::gbc_status_t status,
	output gbc_pkg::gbc_cmd_t    cmd
);

	gbc_pkg::gbc_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		glyph_ready = 1'b0;
		case (state_q)
			gbc_pkg::ST_IDLE: begin
				glyph_ready = 1'b1;
				if (glyph_valid) begin
					if (glyph_op == gbc_pkg::OP_HEADER) begin
						cmd.load_hdr = 1'b1;
					end else if (status.active) begin
						cmd.load_data = 1'b1;
						state_d       = gbc_pkg::ST_SEG;
					end
				end
			end
			gbc_pkg::ST_SEG: begin
				cmd.seg_calc = 1'b1;
				state_d      = gbc_pkg::ST_EMIT;
			end
			gbc_pkg::ST_EMIT: begin
				if (!status.vis) begin
					cmd.advance = 1'b1;
					state_d     = status.item_end ? gbc_pkg::ST_FLUSH : gbc_pkg::ST_SEG;
				end else if (status.can_emit) begin
					cmd.emit = 1'b1;
					if (status.word_end) begin
						cmd.advance = 1'b1;
						state_d     = status.item_end ? gbc_pkg::ST_FLUSH : gbc_pkg::ST_SEG;
					end else begin
						cmd.next_word = 1'b1;
					end
				end
			end
			gbc_pkg::ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush = 1'b1;
					state_d   = gbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/gbc_dp.sv]
// Datapath of the glyph blitter: configuration, glyph position state, segment
// geometry, mask builder, one-result hold stage and output register. Uses gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbc_dp (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     cfg_we,
	input  wire  [gbc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire  [gbc_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  gbc_pkg::glyph_item_t                    glyph,
	output gbc_pkg::blit_item_t                     blit,
	output logic                                    blit_valid,
	input  wire                                     blit_ready,
	input  gbc_pkg::gbc_cmd_t                       cmd,
	output gbc_pkg::gbc_status_t                    status
);

	// Configuration
	logic [10:0] clip_left_q, clip_top_q;
	logic [11:0] clip_width_q, clip_height_q;
	logic [6:0]  wpr_q;
	logic        ink_black_q;

	// Glyph state
	logic signed [15:0] box_x_q, box_y_q;
	logic [7:0]  box_w_q, box_h_q, col_q, row_q;
	logic        hdr_seen_q;
	logic [31:0] data_q;
	logic [4:0]  bit_q;

	// Segment registers
	logic [5:0]         len_q;
	logic [31:0]        seg_bits_q;
	logic signed [18:0] x0_q;
	logic               vis_q;
	logic [6:0]         w_q, w_end_q;
	logic [11:0]        lo_q, hi_q;
	logic [19:0]        row_base_q;

	// Hold stage and output register
	logic        pend_valid_q;
	logic [19:0] pend_addr_q;
	logic [31:0] pend_mask_q;
	logic        out_valid_q;
	gbc_pkg::blit_item_t out_q;

	// Segment geometry
	logic [8:0]         rem_w_c;
	logic [5:0]         avail_c, len_c;
	logic signed [18:0] x0_c, y_c, cl_c, cr_c, ct_c, cb_c, lo_c, hi_c, hi_raw_c, hi_m1_c;
	logic               vis_c;
	logic [31:0]        len_mask_c, seg_bits_c;
	logic [18:0]        row_prod_c;
	logic [6:0]         wpr_wr_c;

	assign rem_w_c  = {1'b0, box_w_q} - {1'b0, col_q};
	assign avail_c  = 6'd32 - {1'b0, bit_q};
	assign len_c    = ({3'b0, avail_c} < rem_w_c) ? avail_c : rem_w_c[5:0];
	assign x0_c     = 19'(box_x_q) + $signed({11'b0, col_q});
	assign y_c      = 19'(box_y_q) + $signed({11'b0, row_q});
	assign cl_c     = $signed({8'b0, clip_left_q});
	assign cr_c     = cl_c + $signed({7'b0, clip_width_q});
	assign ct_c     = $signed({8'b0, clip_top_q});
	assign cb_c     = ct_c + $signed({7'b0, clip_height_q});
	assign lo_c     = (x0_c > cl_c) ? x0_c : cl_c;
	assign hi_raw_c = x0_c + $signed({13'b0, len_c});
	assign hi_c     = (hi_raw_c > cr_c) ? cr_c : hi_raw_c;
	assign hi_m1_c  = hi_c - 19'sd1;
	assign vis_c    = (y_c >= ct_c) && (y_c < cb_c) && (lo_c < hi_c);
	assign len_mask_c = 32'hFFFF_FFFF >> (6'd32 - len_c);
	assign seg_bits_c = (data_q >> bit_q) & len_mask_c;
	assign row_prod_c = 19'(y_c[11:0]) * 19'(wpr_q);

	// Mask for the current framebuffer word
	logic [11:0]        wb_c;
	logic signed [18:0] d_c, t_full_c;
	logic [63:0]        win64_c;
	logic [31:0]        shifted_c, low_mask_c, high_mask_c, mask_c;
	logic signed [12:0] lo_rel_c, hi_rel_c;
	logic [19:0]        addr_c;

	assign wb_c      = {w_q, 5'b0};
	assign d_c       = x0_q - $signed({7'b0, wb_c});
	assign t_full_c  = 19'sd32 - d_c;
	assign win64_c   = {seg_bits_q, 32'b0} >> t_full_c[5:0];
	assign shifted_c = win64_c[31:0];
	assign lo_rel_c  = $signed({1'b0, lo_q}) - $signed({1'b0, wb_c});
	assign hi_rel_c  = $signed({1'b0, hi_q}) - $signed({1'b0, wb_c});
	assign low_mask_c  = (lo_rel_c <= 13'sd0) ? 32'hFFFF_FFFF
		: (32'hFFFF_FFFF << lo_rel_c[4:0]);
	assign high_mask_c = (hi_rel_c >= 13'sd32) ? 32'hFFFF_FFFF
		: ~(32'hFFFF_FFFF << hi_rel_c[4:0]);
	assign mask_c    = shifted_c & low_mask_c & high_mask_c;
	assign addr_c    = row_base_q + {13'b0, w_q};

	// Position after this segment
	logic [5:0] bit_next_c;
	logic [8:0] col_next_c, row_next_c;
	logic       row_wrap_c;

	assign bit_next_c = {1'b0, bit_q} + len_q;
	assign col_next_c = {1'b0, col_q} + {3'b0, len_q};
	assign row_wrap_c = col_next_c >= {1'b0, box_w_q};
	assign row_next_c = {1'b0, row_q} + 9'd1;

	// Status toward the controller
	logic out_free_c;
	assign out_free_c = !out_valid_q || blit_ready;

	always_comb begin
		status.active   = hdr_seen_q && (box_w_q != 8'd0) && (row_q < box_h_q);
		status.vis      = vis_q;
		status.word_end = (w_q == w_end_q);
		status.item_end = bit_next_c[5] || (row_wrap_c && (row_next_c >= {1'b0, box_h_q}));
		status.can_emit = !pend_valid_q || out_free_c;
		status.out_free = out_free_c;
	end

	// Saturate the row length on write
	assign wpr_wr_c = (cfg_data[6:0] > 7'(gbc_pkg::MAX_ROW_WORDS))
		? 7'(gbc_pkg::MAX_ROW_WORDS) : cfg_data[6:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_width_q  <= '0;
			clip_height_q <= '0;
			wpr_q         <= 7'd8;
			ink_black_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				gbc_pkg::REG_CLIP_LEFT:     clip_left_q   <= cfg_data[10:0];
				gbc_pkg::REG_CLIP_TOP:      clip_top_q    <= cfg_data[10:0];
				gbc_pkg::REG_CLIP_WIDTH:    clip_width_q  <= cfg_data;
				gbc_pkg::REG_CLIP_HEIGHT:   clip_height_q <= cfg_data;
				gbc_pkg::REG_WORDS_PER_ROW: wpr_q         <= wpr_wr_c;
				gbc_pkg::REG_INK_BLACK:     ink_black_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Glyph box and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q    <= '0;
			box_y_q    <= '0;
			box_w_q    <= '0;
			box_h_q    <= '0;
			col_q      <= '0;
			row_q      <= '0;
			hdr_seen_q <= 1'b0;
			bit_q      <= '0;
		end else if (cmd.load_hdr) begin
			box_x_q    <= glyph.target_x;
			box_y_q    <= glyph.target_y;
			box_w_q    <= glyph.glyph_width;
			box_h_q    <= glyph.glyph_height;
			col_q      <= '0;
			row_q      <= '0;
			hdr_seen_q <= 1'b1;
		end else if (cmd.load_data) begin
			bit_q <= '0;
		end else if (cmd.advance) begin
			bit_q <= bit_next_c[4:0];
			if (row_wrap_c) begin
				col_q <= '0;
				row_q <= row_next_c[7:0];
			end else begin
				col_q <= col_next_c[7:0];
			end
		end
	end

	// Data word and segment geometry
	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			data_q <= glyph.bitmap_word;
		end
		if (cmd.seg_calc) begin
			len_q      <= len_c;
			seg_bits_q <= seg_bits_c;
			x0_q       <= x0_c;
			lo_q       <= lo_c[11:0];
			hi_q       <= hi_c[11:0];
			w_q        <= lo_c[11:5];
			w_end_q    <= hi_m1_c[11:5];
			row_base_q <= 20'(row_prod_c);
		end else if (cmd.next_word) begin
			w_q <= w_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= 1'b0;
		end else if (cmd.seg_calc) begin
			vis_q <= vis_c;
		end
	end

	// Hold one result back so the final one of a transaction can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if ((cmd.emit || cmd.flush) && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (blit_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_addr_q <= addr_c;
			pend_mask_q <= mask_c;
		end
		if ((cmd.emit || cmd.flush) && pend_valid_q) begin
			out_q.word_address <= pend_addr_q;
			out_q.pixel_mask   <= pend_mask_q;
			out_q.clear_pixels <= ink_black_q;
			out_q.last         <= cmd.flush;
		end
	end

	assign blit       = out_q;
	assign blit_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/glyph_blit_clipped_1bit.sv]
// Top level of the clipped 1-bit glyph blitter: joins controller and datapath.
// Depends on gbc_pkg, gbc_ctrl and gbc_dp.
//
//   channel   direction   handshake                  payload
//   glyph     in          glyph_valid / glyph_ready  gbc_pkg::glyph_item_t
//   blit      out         blit_valid / blit_ready    gbc_pkg::blit_item_t
//   cfg       in          cfg_we (no wait)           cfg_index, cfg_data
//
// A header, or a data word that draws nothing (no header yet, empty or finished
// glyph), is taken in the idle state alone. Any other data word is accepted and
// then walked by the controller one row segment at a time: a geometry step per
// segment, then a step per framebuffer word touched, or one step past a fully
// clipped segment, and last a step that releases the final result. Ready is
// high only while idle; a result may still sit in the output register then.
// A stalled output stops the walk at the next result. Reset clears control
// state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module glyph_blit_clipped_1bit (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             glyph_valid,
	output logic                            glyph_ready,
	input  gbc_pkg::glyph_item_t            glyph,
	output logic                            blit_valid,
	input  wire                             blit_ready,
	output gbc_pkg::blit_item_t             blit,
	input  wire                             cfg_we,
	input  wire  [gbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [gbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gbc_pkg::gbc_cmd_t    cmd;
	gbc_pkg::gbc_status_t status;

	// Sequencer
	gbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_valid (glyph_valid),
		.glyph_op    (glyph.operation),
		.glyph_ready (glyph_ready),
		.status      (status),
		.cmd         (cmd)
	);

	// Geometry, masks and output
	gbc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.glyph      (glyph),
		.blit       (blit),
		.blit_valid (blit_valid),
		.blit_ready (blit_ready),
		.cmd        (cmd),
		.status     (status)
	);

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the clipped 1-bit glyph blitter: directed and random glyph streams
// checked word by word against an in-bench blit predictor. Uses gbc_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;
	import gbc_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_RESULTS   = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  glyph_valid;
	logic                  glyph_ready;
	glyph_item_t           glyph;
	logic                  blit_valid;
	logic                  blit_ready;
	blit_item_t            blit;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit gaps_on        = 1'b1;
	bit stalls_on      = 1'b1;
	int mismatch_count = 0;

	// Expected blit transactions, oldest first
	blit_item_t blit_expect_q[$];

	// Predictor copy of the registers
	logic [10:0] mdl_clip_left  = '0;
	logic [10:0] mdl_clip_top   = '0;
	logic [11:0] mdl_clip_w     = '0;
	logic [11:0] mdl_clip_h     = '0;
	logic [6:0]  mdl_row_words  = 7'd8;
	logic        mdl_ink_black  = 1'b1;

	// Predictor copy of the glyph walk
	int glyph_x    = 0;
	int glyph_y    = 0;
	int glyph_w    = 0;
	int glyph_h    = 0;
	int next_col   = 0;
	int next_row   = 0;
	bit glyph_open = 1'b0;

	glyph_blit_clipped_1bit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_valid (glyph_valid),
		.glyph_ready (glyph_ready),
		.glyph       (glyph),
		.blit_valid  (blit_valid),
		.blit_ready  (blit_ready),
		.blit        (blit),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop for a hung run
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	// Drive blit_ready with random stall bursts
	initial begin
		blit_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 6) == 0) begin
				blit_ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				blit_ready <= 1'b1;
			end
		end
	end

	// Compare each blit transaction with the oldest expectation
	always @(posedge clk) begin : check_blit
		blit_item_t exp_item;
		if (arst_n && blit_valid && blit_ready) begin
			if (blit_expect_q.size() == 0) begin
				$error("blit transaction with nothing expected: word_address %h pixel_mask %h",
					blit.word_address, blit.pixel_mask);
				mismatch_count++;
			end else begin
				exp_item = blit_expect_q.pop_front();
				if (blit.word_address !== exp_item.word_address) begin
					$error("word_address mismatch: expected %h, actual %h",
						exp_item.word_address, blit.word_address);
					mismatch_count++;
				end
				if (blit.pixel_mask !== exp_item.pixel_mask) begin
					$error("pixel_mask mismatch: expected %h, actual %h",
						exp_item.pixel_mask, blit.pixel_mask);
					mismatch_count++;
				end
				if (blit.clear_pixels !== exp_item.clear_pixels) begin
					$error("clear_pixels mismatch: expected %b, actual %b",
						exp_item.clear_pixels, blit.clear_pixels);
					mismatch_count++;
				end
				if (blit.last !== exp_item.last) begin
					$error("last mismatch: expected %b, actual %b",
						exp_item.last, blit.last);
					mismatch_count++;
				end
			end
		end
	end

	// Mirror a register write into the predictor
	function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_CLIP_LEFT:     mdl_clip_left = val[10:0];
			REG_CLIP_TOP:      mdl_clip_top  = val[10:0];
			REG_CLIP_WIDTH:    mdl_clip_w    = val[11:0];
			REG_CLIP_HEIGHT:   mdl_clip_h    = val[11:0];
			REG_WORDS_PER_ROW: begin
				mdl_row_words = val[6:0];
				if (mdl_row_words > MAX_ROW_WORDS) mdl_row_words = 7'(MAX_ROW_WORDS);
			end
			REG_INK_BLACK:     mdl_ink_black = val[0];
			default: ;
		endcase
	endfunction

	// Queue one framebuffer word update; returns the new count for this item
	function automatic int push_word(int count, int y, int word, logic [31:0] mask);
		blit_item_t r;
		logic [31:0] addr;
		if (count >= MAX_RESULTS) return count;
		addr = y * int'(mdl_row_words) + word;
		r.word_address = addr[19:0];
		r.pixel_mask   = mask;
		r.clear_pixels = mdl_ink_black;
		r.last         = 1'b0;
		blit_expect_q.push_back(r);
		return count + 1;
	endfunction

	// Walk one accepted item through the clip box and queue the word updates it causes
	function automatic void predict_blit(glyph_item_t it);
		int b, len, x0, y, lo, hi, cl, cr, cur, x, count;
		logic [31:0] mask;
		blit_item_t tail;
		if (it.operation == OP_HEADER) begin
			glyph_x    = int'($signed(it.target_x));
			glyph_y    = int'($signed(it.target_y));
			glyph_w    = int'(it.glyph_width);
			glyph_h    = int'(it.glyph_height);
			next_col   = 0;
			next_row   = 0;
			glyph_open = 1'b1;
			return;
		end
		if (!glyph_open || glyph_w == 0) return;
		count = 0;
		b = 0;
		cl = int'(mdl_clip_left);
		cr = cl + int'(mdl_clip_w);
		while (b < WORD_BITS && next_row < glyph_h) begin
			len = WORD_BITS - b;
			if (glyph_w - next_col < len) len = glyph_w - next_col;
			x0 = glyph_x + next_col;
			y  = glyph_y + next_row;
			lo = (x0 > cl) ? x0 : cl;
			hi = x0 + len;
			if (hi > cr) hi = cr;
			if (y >= int'(mdl_clip_top) && y < int'(mdl_clip_top) + int'(mdl_clip_h) &&
					lo < hi) begin
				cur  = lo / WORD_BITS;
				mask = '0;
				for (x = lo; x < hi; x++) begin
					if (x / WORD_BITS != cur) begin
						count = push_word(count, y, cur, mask);
						cur   = x / WORD_BITS;
						mask  = '0;
					end
					mask[x % WORD_BITS] = it.bitmap_word[b + x - x0];
				end
				count = push_word(count, y, cur, mask);
			end
			b        += len;
			next_col += len;
			if (next_col >= glyph_w) begin
				next_col = 0;
				next_row++;
			end
		end
		// Flag the final word of this item
		if (count > 0) begin
			tail = blit_expect_q.pop_back();
			tail.last = 1'b1;
			blit_expect_q.push_back(tail);
		end
	endfunction

	function automatic glyph_item_t make_header(int x, int y, int w, int h);
		glyph_item_t it;
		it.operation    = OP_HEADER;
		it.target_x     = x[15:0];
		it.target_y     = y[15:0];
		it.glyph_width  = w[7:0];
		it.glyph_height = h[7:0];
		it.bitmap_word  = $urandom;
		return it;
	endfunction

	function automatic glyph_item_t make_data(logic [31:0] bits);
		glyph_item_t it;
		it.operation    = OP_DATA;
		it.target_x     = 16'($urandom_range(0, 65535));
		it.target_y     = 16'($urandom_range(0, 65535));
		it.glyph_width  = 8'($urandom_range(0, 255));
		it.glyph_height = 8'($urandom_range(0, 255));
		it.bitmap_word  = bits;
		return it;
	endfunction

	function automatic logic [31:0] random_bits();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Coordinate near an edge, inside, or anywhere on the 16-bit plane
	function automatic int pick_coord(int lo, int span, int size);
		case ($urandom_range(0, 5))
			0:       return lo - size + int'($urandom_range(0, 2 * size));
			1:       return lo + span - size + int'($urandom_range(0, 2 * size));
			2:       return int'($urandom_range(0, 65535)) - 32768;
			default: return lo + int'($urandom_range(0, span));
		endcase
	endfunction

	// Present one glyph transaction and predict it once accepted
	task automatic send_glyph(glyph_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 11)) begin
				@(negedge clk);
				glyph_valid <= 1'b0;
			end
		end
		@(negedge clk);
		glyph_valid <= 1'b1;
		glyph       <= it;
		do @(posedge clk); while (!glyph_ready);
		predict_blit(it);
	endtask

	// Hold off input until every expected word has come and the block has settled
	task automatic drain_results();
		@(negedge clk);
		glyph_valid <= 1'b0;
		while (blit_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_config(idx, val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic program_regs(logic [11:0] left, logic [11:0] top, logic [11:0] width,
			logic [11:0] height, logic [11:0] row_words, logic [11:0] ink);
		drain_results();
		write_reg(REG_CLIP_LEFT, left);
		write_reg(REG_CLIP_TOP, top);
		write_reg(REG_CLIP_WIDTH, width);
		write_reg(REG_CLIP_HEIGHT, height);
		write_reg(REG_WORDS_PER_ROW, row_words);
		write_reg(REG_INK_BLACK, ink);
	endtask

	// Reset registers: empty clip box, so nothing is drawn; data before a header is dropped
	task automatic test_orphan_data();
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_header(0, 0, 8, 8));
		send_glyph(make_data(32'hFFFF_FFFF));
	endtask

	// Row that straddles two words, surplus bits and a data word after the glyph ends
	task automatic test_word_span();
		program_regs(12'd0, 12'd0, 12'h800, 12'h800, 12'd64, 12'd0);
		send_glyph(make_header(28, 5, 10, 3));
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_data(32'h1234_5678));
		// Blank ink still writes a zero mask
		send_glyph(make_header(64, 0, 32, 1));
		send_glyph(make_data(32'h0000_0000));
	endtask

	// Boxes at the edges of the coordinate range and of the clip box
	task automatic test_extreme_boxes();
		send_glyph(make_header(-32768, 0, 255, 1));
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_header(32767, 32767, 255, 255));
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_header(2047, 0, 1, 255));
		send_glyph(make_data(32'hA5A5_A5A5));
	endtask

	// Zero width or zero height: all data is dropped
	task automatic test_empty_glyphs();
		send_glyph(make_header(10, 10, 0, 5));
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_header(10, 10, 5, 0));
		send_glyph(make_data(32'hFFFF_FFFF));
	endtask

	// Row length zero, saturated and one word; masked clip_left
	task automatic test_row_length();
		program_regs(12'h800, 12'd0, 12'h800, 12'h800, 12'h080, 12'd1);
		send_glyph(make_header(100, 7, 40, 1));
		send_glyph(make_data(32'hF0F0_FFFF));
		send_glyph(make_data(32'h0000_00FF));
		program_regs(12'd0, 12'd0, 12'h800, 12'h800, 12'hFFF, 12'd1);
		send_glyph(make_header(2040, 10, 16, 2));
		send_glyph(make_data(32'hFFFF_FFFF));
		program_regs(12'd0, 12'd0, 12'h800, 12'h800, 12'd1, 12'd0);
		send_glyph(make_header(100, 3, 40, 1));
		send_glyph(make_data(32'hFFFF_FFFF));
		send_glyph(make_data(32'hFFFF_FFFF));
	endtask

	// New register set: fixed extremes or random values with stray upper bits
	task automatic random_config(bit extreme);
		logic [11:0] left, top, width, height, row_words;
		if (extreme) begin
			program_regs(12'h7FF, 12'h7FF, 12'h800, 12'h800, 12'd64, 12'd1);
		end else begin
			left   = {1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047))};
			top    = {1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047))};
			case ($urandom_range(0, 7))
				0:       width = 12'd0;
				1:       width = 12'h800;
				2, 3, 4: width = 12'($urandom_range(1, 96));
				default: width = 12'($urandom_range(0, 2048));
			endcase
			case ($urandom_range(0, 7))
				0:       height = 12'h800;
				1, 2, 3: height = 12'($urandom_range(1, 24));
				default: height = 12'($urandom_range(1, 2048));
			endcase
			case ($urandom_range(0, 3))
				0:       row_words = 12'($urandom_range(0, 4095));
				1:       row_words = 12'd64;
				2:       row_words = 12'd1;
				default: row_words = 12'($urandom_range(1, 64));
			endcase
			program_regs(left, top, width, height, row_words, 12'($urandom_range(0, 4095)));
		end
	endtask

	// Mostly complete glyphs with random content; some noise and cut-short glyphs
	task automatic test_random_glyphs(int n_items);
		int done, kind, w, h, x, y, words, k;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(0, 15);
			case ($urandom_range(0, 9))
				0: begin
					w = $urandom_range(128, 255);
					h = $urandom_range(1, 2);
				end
				1: begin
					w = $urandom_range(1, 3);
					h = $urandom_range(128, 255);
				end
				default: begin
					w = $urandom_range(1, 40);
					h = $urandom_range(1, 8);
				end
			endcase
			x = pick_coord(int'(mdl_clip_left), int'(mdl_clip_w), w);
			y = pick_coord(int'(mdl_clip_top), int'(mdl_clip_h), h);
			words = (w * h + 31) / 32;
			if (kind == 0) begin
				send_glyph(make_data(random_bits()));
			end else if (kind == 1) begin
				// Cut short: the next header abandons it
				send_glyph(make_header(x, y, w, h));
				k = $urandom_range(0, words - 1);
				repeat (k) send_glyph(make_data(random_bits()));
				done += 1 + k;
			end else if (kind == 2) begin
				send_glyph(make_header($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 255), $urandom_range(0, 255)));
				done++;
			end else begin
				send_glyph(make_header(x, y, w, h));
				repeat (words) send_glyph(make_data(random_bits()));
				done += 1 + words;
				if (kind == 3) send_glyph(make_data(random_bits()));
			end
			if ($urandom_range(0, 24) == 0) drain_results();
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		glyph_valid = 1'b0;
		glyph       = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_orphan_data();
		test_word_span();
		test_extreme_boxes();
		test_empty_glyphs();
		test_row_length();

		random_config(1'b0);
		test_random_glyphs(80);
		random_config(1'b1);
		test_random_glyphs(70);
		random_config(1'b0);
		// Final stretch runs at full rate on both sides
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		test_random_glyphs(70);

		drain_results();
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[glyph_blit_clipped_1bit.f]
rtl/gbc_pkg.sv
rtl/gbc_ctrl.sv
rtl/gbc_dp.sv
rtl/glyph_blit_clipped_1bit.sv
tb/sv/tb_top.sv
